### rtl/rrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants of the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // ready queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command queue between front and back
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  // field widths
  localparam int ID_W     = 16;
  localparam int TIME_W   = 16;
  localparam int SUM_W    = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_RAN     = 3'd0,
    ST_PREEMPT = 3'd1,
    ST_FINISH  = 3'd2,
    ST_IDLE    = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // classified command kind
  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] burst;
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  // one ready queue entry
  typedef struct packed {
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
  } entry_t;

  // back end sequencer
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } bk_state_t;

  // wrap-around successor of a ready queue index
  function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] idx);
    logic [QIDX_W-1:0] res;
    if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + QIDX_W'(1);
    end
    return res;
  endfunction

endpackage

### rtl/rrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_front
// Takes input beats, classifies them into arrival or tick commands and holds
// them in a short command queue for the back end.
// ----------------------------------------------------------------------------
module rrs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        mode,
  input  logic [rrs_pkg::ID_W-1:0]    proc_id,
  input  logic [rrs_pkg::TIME_W-1:0]  burst_length,
  output logic                        busy,
  output rrs_pkg::cmd_head_t          head,
  input  logic                        pop
);

  rrs_pkg::cmd_t                     slots [rrs_pkg::CMDQ_DEPTH];
  logic [rrs_pkg::CMDQ_PTR_W-1:0]    wr_ptr;
  logic [rrs_pkg::CMDQ_PTR_W-1:0]    rd_ptr;
  logic [rrs_pkg::CMDQ_CNT_W-1:0]    count;
  logic                              push;
  logic                              do_pop;
  rrs_pkg::cmd_t                     new_cmd;

  // accept a beat whenever a slot is free
  assign busy   = (count == rrs_pkg::CMDQ_CNT_W'(rrs_pkg::CMDQ_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (count != '0);

  // classify the incoming beat
  always_comb begin
    new_cmd.kind    = mode ? rrs_pkg::CMD_TICK : rrs_pkg::CMD_ARRIVE;
    new_cmd.proc_id = proc_id;
    new_cmd.burst   = burst_length;
  end

  // command storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rrs_pkg::CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + rrs_pkg::CMDQ_PTR_W'(1);
      end
      priority if (push && !do_pop) begin
        count <= count + rrs_pkg::CMDQ_CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - rrs_pkg::CMDQ_CNT_W'(1);
      end else begin
        count <= count;
      end
    end
  end

  // head of queue toward the back end
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];

endmodule

### rtl/rrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_back
// Executes arrival and tick commands against the ready queue memory and
// produces one registered result per command where one is due.
// ----------------------------------------------------------------------------
module rrs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  rrs_pkg::cmd_head_t            head,
  output logic                          pop,
  input  logic                          cfg_write,
  input  logic [rrs_pkg::TIME_W-1:0]    cfg_data,
  output logic                          done,
  output logic [rrs_pkg::STATUS_W-1:0]  status,
  output logic [rrs_pkg::ID_W-1:0]      slice_proc_id,
  output logic [rrs_pkg::TIME_W-1:0]    wait_time,
  output logic [rrs_pkg::SUM_W-1:0]     total_wait,
  output logic [rrs_pkg::COUNT_W-1:0]   queue_count
);

  rrs_pkg::bk_state_t               state;
  rrs_pkg::bk_state_t               state_next;
  rrs_pkg::entry_t                  mem [rrs_pkg::QUEUE_DEPTH];
  rrs_pkg::entry_t                  rd_data;
  logic                             rd_en;
  logic                             mem_we;
  logic [rrs_pkg::QIDX_W-1:0]       mem_waddr;
  rrs_pkg::entry_t                  mem_wdata;

  logic [rrs_pkg::QIDX_W-1:0]       head_index;
  logic [rrs_pkg::QIDX_W-1:0]       tail_index;
  logic [rrs_pkg::QCNT_W-1:0]       entry_count;
  logic [rrs_pkg::TIME_W-1:0]       slice_counter;
  logic [rrs_pkg::TIME_W-1:0]       current_time;
  logic [rrs_pkg::SUM_W-1:0]        wait_sum;
  logic [rrs_pkg::TIME_W-1:0]       quantum;
  rrs_pkg::status_t                 status_q;

  logic                             is_arrive;
  logic                             q_full;
  logic                             q_empty;
  logic                             finishing;
  logic                             expiring;
  logic [rrs_pkg::TIME_W-1:0]       wait_calc;
  logic [rrs_pkg::SUM_W:0]          sum_wide;
  logic [rrs_pkg::SUM_W-1:0]        sum_sat;
  rrs_pkg::entry_t                  upd_entry;

  assign is_arrive = (head.cmd.kind == rrs_pkg::CMD_ARRIVE);
  assign q_full    = (entry_count == rrs_pkg::QCNT_W'(rrs_pkg::QUEUE_DEPTH));
  assign q_empty   = (entry_count == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrs_pkg::BK_IDLE: begin
        if (head.valid && !is_arrive && !q_empty) begin
          state_next = rrs_pkg::BK_EXEC;
        end
      end
      rrs_pkg::BK_EXEC: begin
        state_next = rrs_pkg::BK_IDLE;
      end
      default: begin
        state_next = rrs_pkg::BK_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop   = 1'b0;
    rd_en = 1'b0;
    unique case (state)
      rrs_pkg::BK_IDLE: begin
        pop   = head.valid;
        rd_en = head.valid && !is_arrive && !q_empty;
      end
      rrs_pkg::BK_EXEC: begin
        pop   = 1'b0;
        rd_en = 1'b0;
      end
      default: begin
        pop   = 1'b0;
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrs_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // slice arithmetic on the head entry
  assign finishing = (rd_data.remaining <= rrs_pkg::TIME_W'(1));
  assign expiring  = (slice_counter >= quantum);
  assign wait_calc = current_time + rrs_pkg::TIME_W'(1) - rd_data.arrival - rd_data.burst;
  assign sum_wide  = {1'b0, wait_sum} + (rrs_pkg::SUM_W + 1)'(wait_calc);
  assign sum_sat   = sum_wide[rrs_pkg::SUM_W] ? '1 : sum_wide[rrs_pkg::SUM_W-1:0];

  always_comb begin
    upd_entry           = rd_data;
    upd_entry.remaining = rd_data.remaining - rrs_pkg::TIME_W'(1);
  end

  // memory write selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tail_index;
    mem_wdata = upd_entry;
    if (state == rrs_pkg::BK_IDLE) begin
      mem_we              = pop && is_arrive && !q_full;
      mem_waddr           = tail_index;
      mem_wdata.proc_id   = head.cmd.proc_id;
      mem_wdata.arrival   = current_time;
      mem_wdata.burst     = head.cmd.burst;
      mem_wdata.remaining = head.cmd.burst;
    end else if (!finishing) begin
      mem_we    = 1'b1;
      mem_waddr = expiring ? tail_index : head_index;
    end
  end

  // ready queue memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[head_index];
    end
  end

  // scheduler state and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index    <= '0;
      tail_index    <= '0;
      entry_count   <= '0;
      slice_counter <= rrs_pkg::TIME_W'(1);
      current_time  <= '0;
      wait_sum      <= '0;
      quantum       <= rrs_pkg::TIME_W'(1);
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        quantum <= cfg_data;
      end
      if (state == rrs_pkg::BK_IDLE && pop) begin
        if (is_arrive) begin
          if (q_full) begin
            done        <= 1'b1;
            status_q    <= rrs_pkg::ST_FULL;
            slice_proc_id <= head.cmd.proc_id;
            wait_time   <= '0;
            total_wait  <= wait_sum;
            queue_count <= rrs_pkg::COUNT_W'(entry_count);
          end else begin
            tail_index  <= rrs_pkg::next_slot(tail_index);
            entry_count <= entry_count + rrs_pkg::QCNT_W'(1);
          end
        end else if (q_empty) begin
          current_time  <= current_time + rrs_pkg::TIME_W'(1);
          done          <= 1'b1;
          status_q      <= rrs_pkg::ST_IDLE;
          slice_proc_id <= '0;
          wait_time     <= '0;
          total_wait    <= wait_sum;
          queue_count   <= rrs_pkg::COUNT_W'(entry_count);
        end
      end else if (state == rrs_pkg::BK_EXEC) begin
        current_time  <= current_time + rrs_pkg::TIME_W'(1);
        done          <= 1'b1;
        slice_proc_id <= rd_data.proc_id;
        priority if (finishing) begin
          head_index    <= rrs_pkg::next_slot(head_index);
          entry_count   <= entry_count - rrs_pkg::QCNT_W'(1);
          slice_counter <= rrs_pkg::TIME_W'(1);
          wait_sum      <= sum_sat;
          status_q      <= rrs_pkg::ST_FINISH;
          wait_time     <= wait_calc;
          total_wait    <= sum_sat;
          queue_count   <= rrs_pkg::COUNT_W'(entry_count - rrs_pkg::QCNT_W'(1));
        end else if (expiring) begin
          head_index    <= rrs_pkg::next_slot(head_index);
          tail_index    <= rrs_pkg::next_slot(tail_index);
          slice_counter <= rrs_pkg::TIME_W'(1);
          status_q      <= rrs_pkg::ST_PREEMPT;
          wait_time     <= wait_calc;
          total_wait    <= wait_sum;
          queue_count   <= rrs_pkg::COUNT_W'(entry_count);
        end else begin
          slice_counter <= slice_counter + rrs_pkg::TIME_W'(1);
          status_q      <= rrs_pkg::ST_RAN;
          wait_time     <= '0;
          total_wait    <= wait_sum;
          queue_count   <= rrs_pkg::COUNT_W'(entry_count);
        end
      end
    end
  end

  assign status = status_q;

endmodule

### rtl/round_robin_time_slice_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler
// Round-robin scheduler with a programmable quantum: arrivals enter a ready
// queue, ticks run the head process one unit and finish, requeue or keep it.
//
//   channel  handshake          payload
//   in       start / busy       mode, proc_id, burst_length
//   cfg      cfg_write          cfg_data (quantum)
//   out      done (strobe)      status, slice_proc_id, wait_time,
//                               total_wait, queue_count
//
// The front takes one beat per cycle until its two-entry command queue fills.
// The back end handles an arrival or an idle tick in its idle state; a tick
// with work queued also passes its exec state: the head entry is read from
// the queue memory into a register, then updated and written back.
// Reset clears pointers, counts, time and wait sum and sets quantum to 1;
// queue memory is not cleared. Results are single-cycle strobes.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [rrs_pkg::ID_W-1:0]      proc_id,
  input  logic [rrs_pkg::TIME_W-1:0]    burst_length,
  input  logic                          cfg_write,
  input  logic [rrs_pkg::TIME_W-1:0]    cfg_data,
  output logic                          done,
  output logic [rrs_pkg::STATUS_W-1:0]  status,
  output logic [rrs_pkg::ID_W-1:0]      slice_proc_id,
  output logic [rrs_pkg::TIME_W-1:0]    wait_time,
  output logic [rrs_pkg::SUM_W-1:0]     total_wait,
  output logic [rrs_pkg::COUNT_W-1:0]   queue_count
);

  rrs_pkg::cmd_head_t cmd_head;
  logic               cmd_pop;

  // accept and classify
  rrs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .proc_id      (proc_id),
    .burst_length (burst_length),
    .busy         (busy),
    .head         (cmd_head),
    .pop          (cmd_pop)
  );

  // execute against the ready queue
  rrs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (cmd_head),
    .pop           (cmd_pop),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .slice_proc_id (slice_proc_id),
    .wait_time     (wait_time),
    .total_wait    (total_wait),
    .queue_count   (queue_count)
  );

  // queue occupancy never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (queue_count <= rrs_pkg::COUNT_W'(rrs_pkg::QUEUE_DEPTH)))
    else $error("queue count above depth");

  // a rejected arrival only happens with a full queue
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (done && status == rrs_pkg::ST_FULL) |->
      (queue_count == rrs_pkg::COUNT_W'(rrs_pkg::QUEUE_DEPTH)))
    else $error("arrival rejected with room in queue");

  // an idle tick reports an empty queue and no process
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == rrs_pkg::ST_IDLE) |->
      (queue_count == '0 && slice_proc_id == '0 && wait_time == '0))
    else $error("idle tick with queued work");

  // a plain run reports no waiting time
  a_ran_nowait: assert property (@(posedge clk) disable iff (rst)
    (done && status == rrs_pkg::ST_RAN) |-> (wait_time == '0 && queue_count != '0))
    else $error("running slice reports wait time");

endmodule
